// ===== hw/rtl/ffsa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the first-fit slot allocator: status and opcode codes,
// controller states, and the command/status structs between controller and datapath.
// No dependencies.
package ffsa_pkg;

    localparam int DEV_W    = 16;
    localparam int KIND_W   = 8;
    localparam int AUX_W    = 32;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_UNUSED    = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL,
        S_EMIT
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic    capture;   // latch the input transaction, start scan at slot 0
        logic    advance;   // step the scan to the next slot
        logic    alloc;     // write the current slot and mark it busy
        logic    release_op;// clear the busy flag of the captured release slot
        logic    res_load;  // latch res_code as the pending result
        status_t res_code;
        logic    emit;      // move the pending result into the output register
    } ctrl_t;

    // Datapath -> controller status
    typedef struct packed {
        logic busy_hit;   // current scan slot is occupied
        logic dev_match;  // current scan slot holds the captured device
        logic last_idx;   // current scan slot is the last one
        logic rel_hit;    // release slot is in the table and occupied
        logic out_free;   // output register can take a result this cycle
    } stat_t;

endpackage

// ===== hw/rtl/ffsa_in_if.sv =====
`timescale 1ns / 1ps
// Request channel of the slot allocator: valid/ready plus request payload.
// Depends on ffsa_pkg.
interface ffsa_in_if;
    import ffsa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [DEV_W-1:0]         device_id;
    logic [KIND_W-1:0]        dev_kind;
    logic signed [AUX_W-1:0]  aux_word;
    logic [SLOT_W-1:0]        release_slot;

    modport source (output valid, cmd, device_id, dev_kind, aux_word, release_slot,
                    input ready);
    modport sink   (input valid, cmd, device_id, dev_kind, aux_word, release_slot,
                    output ready);
endinterface

// ===== hw/rtl/ffsa_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the slot allocator: valid/ready plus status and slot.
// Depends on ffsa_pkg.
interface ffsa_out_if;
    import ffsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

// ===== hw/rtl/ffsa_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the slot allocator: busy flags, entry memory, scan index,
// captured request and output register. Depends on ffsa_pkg.
module ffsa_datapath #(
    parameter int ENTRIES = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ffsa_pkg::ctrl_t                ctrl,
    output ffsa_pkg::stat_t                stat,
    input  logic [ffsa_pkg::DEV_W-1:0]     device_id,
    input  logic [ffsa_pkg::KIND_W-1:0]    dev_kind,
    input  logic signed [ffsa_pkg::AUX_W-1:0] aux_word,
    input  logic [ffsa_pkg::SLOT_W-1:0]    release_slot,
    input  logic                           out_ready,
    output logic                           out_valid,
    output ffsa_pkg::status_t              out_status,
    output logic [ffsa_pkg::SLOT_W-1:0]    out_slot
);
    import ffsa_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW = 9;  // holds any slot index and ENTRIES itself

    typedef struct packed {
        logic [AUX_W-1:0]  aux;
        logic [KIND_W-1:0] kind;
        logic [DEV_W-1:0]  dev;
    } entry_t;

    entry_t              mem [ENTRIES];
    entry_t              rd_reg;
    logic [ENTRIES-1:0]  busy_reg;

    logic [IW-1:0]       idx_reg, idx_next;
    logic [DEV_W-1:0]    dev_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [AUX_W-1:0]    aux_reg;
    logic [SLOT_W-1:0]   rel_reg;

    status_t             res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    logic [XW-1:0]       rel_wide;
    logic [XW-1:0]       idx_wide;
    logic [IW-1:0]       rel_idx;
    logic                rel_in_range;
    logic [SLOT_W-1:0]   res_slot_next;

    // Scan index; the memory is addressed with the next index, so its registered read lines up with the compare
    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.capture)
        begin
            idx_next = '0;
        end
        else if (ctrl.advance)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            dev_reg  <= device_id;
            kind_reg <= dev_kind;
            aux_reg  <= aux_word;
            rel_reg  <= release_slot;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.alloc)
        begin
            mem[idx_reg] <= '{aux: aux_reg, kind: kind_reg, dev: dev_reg};
        end
        rd_reg <= mem[idx_next];
    end

    assign rel_wide     = XW'(rel_reg);
    assign idx_wide     = XW'(idx_reg);
    assign rel_idx      = rel_wide[IW-1:0];
    assign rel_in_range = rel_wide < XW'(ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (ctrl.alloc)
            begin
                busy_reg[idx_reg] <= 1'b1;
            end
            if (ctrl.release_op && rel_in_range)
            begin
                busy_reg[rel_idx] <= 1'b0;
            end
        end
    end

    assign stat.busy_hit  = busy_reg[idx_reg];
    assign stat.dev_match = (rd_reg.dev == dev_reg);
    assign stat.last_idx  = (idx_reg == IW'(ENTRIES - 1));
    assign stat.rel_hit   = rel_in_range && busy_reg[rel_idx];
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign res_slot_next = (ctrl.res_code == ST_ALLOCATED) ? idx_wide[SLOT_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.res_load)
        begin
            res_status_reg <= ctrl.res_code;
            res_slot_reg   <= res_slot_next;
        end
        if (ctrl.emit)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

`ifndef SYNTHESIS
    a_alloc_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.alloc |-> !busy_reg[idx_reg])
        else $error("allocation overwrites a busy slot");

    a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.alloc |=> busy_reg[$past(idx_reg)])
        else $error("allocated slot not marked busy");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance |-> !stat.last_idx)
        else $error("scan advanced past the last slot");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.emit && res_status_reg != ST_ALLOCATED) |=> out_slot_reg == '0)
        else $error("non-allocation result carries a nonzero slot");
`endif

endmodule

// ===== hw/rtl/ffsa_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the slot allocator: sequences capture, slot scan, release
// and result hand-off. Depends on ffsa_pkg.
module ffsa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_cmd,
    input  ffsa_pkg::stat_t  stat,
    output ffsa_pkg::ctrl_t  ctrl,
    output logic             in_ready
);
    import ffsa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_cmd == OP_RELEASE) ? S_REL : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stat.busy_hit || stat.dev_match || stat.last_idx)
                begin
                    state_next = S_EMIT;
                end
            end
            S_REL:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '{res_code: ST_FULL, default: 1'b0};
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
            end
            S_SCAN:
            begin
                if (!stat.busy_hit)
                begin
                    ctrl.alloc    = 1'b1;
                    ctrl.res_load = 1'b1;
                    ctrl.res_code = ST_ALLOCATED;
                end
                else if (stat.dev_match)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_code = ST_DUPLICATE;
                end
                else if (stat.last_idx)
                begin
                    ctrl.res_load = 1'b1;
                    ctrl.res_code = ST_FULL;
                end
                else
                begin
                    ctrl.advance = 1'b1;
                end
            end
            S_REL:
            begin
                ctrl.release_op = 1'b1;
                ctrl.res_load   = 1'b1;
                ctrl.res_code   = stat.rel_hit ? ST_RELEASED : ST_UNUSED;
            end
            S_EMIT:
            begin
                ctrl.emit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.capture, ctrl.advance, ctrl.res_load, ctrl.emit}))
        else $error("controller issued conflicting commands");

    a_capture_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.capture |=> (state_reg == S_SCAN || state_reg == S_REL))
        else $error("captured transaction did not start work");

    a_result_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.res_load |=> state_reg == S_EMIT)
        else $error("result loaded without moving to hand-off");
`endif

endmodule

// ===== hw/rtl/first_fit_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// Flow: an allocate result passes from the scan into the pending result register, then into
//   the output register once that is free; k (1..ENTRIES) slots are scanned, one slot per cycle.
// A release result passes through the release state instead of the scan. One transaction at a
//   time: a new request is taken only after the previous result has entered the output register.
// Reset (rst_n, async, active low) clears all busy flags at once; no clearing pass.
// A finished result waits in the output register while the next request is taken.
module first_fit_slot_allocator_top #(
    parameter int ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ffsa_in_if.sink     in_ch,
    ffsa_out_if.source  out_ch
);
    import ffsa_pkg::*;

    ctrl_t             ctrl;
    stat_t             stat;
    logic              in_ready;
    logic              out_valid;
    status_t           out_status;
    logic [SLOT_W-1:0] out_slot;

    // Controller: holds the state machine; in_ready is high only while idle
    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    // Datapath: busy flags, entry memory, scan index and output register
    ffsa_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .device_id    (in_ch.device_id),
        .dev_kind     (in_ch.dev_kind),
        .aux_word     (in_ch.aux_word),
        .release_slot (in_ch.release_slot),
        .out_ready    (out_ch.ready),
        .out_valid    (out_valid),
        .out_status   (out_status),
        .out_slot     (out_slot)
    );

    assign in_ch.ready   = in_ready;
    assign out_ch.valid  = out_valid;
    assign out_ch.status = out_status;
    assign out_ch.slot   = out_slot;

endmodule
